// File: src/kc2km_pkg.sv
// ----------------------------------------------------------------------------
// kc2km_pkg: shared types and constants for the key matrix block
// Holds the word formats, the event kinds, the modifier codes and the key map.
// ----------------------------------------------------------------------------
package kc2km_pkg;

    typedef logic [7:0][7:0] matrix_t;

    typedef enum logic [2:0] {
        KIND_DOWN  = 3'd0,
        KIND_UP    = 3'd1,
        KIND_MOD   = 3'd2,
        KIND_FRAME = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] key_code;
        logic       option_held;
        logic       shift_held;
        logic       control_held;
    } in_word_t;

    typedef struct packed {
        logic [7:0] row_0;
        logic [7:0] row_1;
        logic [7:0] row_2;
        logic [7:0] row_3;
        logic [7:0] row_4;
        logic [7:0] row_5;
        logic [7:0] row_6;
        logic [7:0] row_7;
    } out_word_t;

    typedef struct packed {
        matrix_t    rows;
        logic       caps_pending;
        logic [3:0] caps_count;
    } state_t;

    localparam logic [7:0] ROW_RESET      = 8'hbf;
    localparam logic [3:0] HOLD_RESET     = 4'd2;
    localparam logic [3:0] CAPS_COUNT_MAX = 4'd15;

    localparam logic [6:0] CODE_SHIFT_L = 7'd56;
    localparam logic [6:0] CODE_CAPS    = 7'd57;
    localparam logic [6:0] CODE_ALT_L   = 7'd58;
    localparam logic [6:0] CODE_CTRL    = 7'd59;
    localparam logic [6:0] CODE_SHIFT_R = 7'd60;
    localparam logic [6:0] CODE_ALT_R   = 7'd61;

    // Matrix bits touched by a key down or key up of a host key code.
    function automatic matrix_t key_mask(input logic [6:0] code);
        matrix_t m;
        m = '0;
        case (code)
            7'd6:   m[0][1] = 1'b1;
            7'd7:   m[0][2] = 1'b1;
            7'd8:   m[0][3] = 1'b1;
            7'd9:   m[0][4] = 1'b1;
            7'd0:   m[1][0] = 1'b1;
            7'd1:   m[1][1] = 1'b1;
            7'd2:   m[1][2] = 1'b1;
            7'd3:   m[1][3] = 1'b1;
            7'd5:   m[1][4] = 1'b1;
            7'd12:  m[2][0] = 1'b1;
            7'd13:  m[2][1] = 1'b1;
            7'd14:  m[2][2] = 1'b1;
            7'd15:  m[2][3] = 1'b1;
            7'd17:  m[2][4] = 1'b1;
            7'd18:  m[3][0] = 1'b1;
            7'd19:  m[3][1] = 1'b1;
            7'd20:  m[3][2] = 1'b1;
            7'd21:  m[3][3] = 1'b1;
            7'd23:  m[3][4] = 1'b1;
            7'd29:  m[4][0] = 1'b1;
            7'd25:  m[4][1] = 1'b1;
            7'd28:  m[4][2] = 1'b1;
            7'd26:  m[4][3] = 1'b1;
            7'd22:  m[4][4] = 1'b1;
            7'd35:  m[5][0] = 1'b1;
            7'd31:  m[5][1] = 1'b1;
            7'd34:  m[5][2] = 1'b1;
            7'd32:  m[5][3] = 1'b1;
            7'd16:  m[5][4] = 1'b1;
            7'd36:  m[6][0] = 1'b1;
            7'd37:  m[6][1] = 1'b1;
            7'd40:  m[6][2] = 1'b1;
            7'd38:  m[6][3] = 1'b1;
            7'd4:   m[6][4] = 1'b1;
            7'd49:  m[7][0] = 1'b1;
            7'd46:  m[7][2] = 1'b1;
            7'd45:  m[7][3] = 1'b1;
            7'd11:  m[7][4] = 1'b1;
            7'd30:  begin m[0][0] = 1'b1; m[3][3] = 1'b1; end
            7'd33:  begin m[0][0] = 1'b1; m[3][2] = 1'b1; end
            7'd39:  begin m[7][1] = 1'b1; m[5][0] = 1'b1; end
            7'd41:  begin m[7][1] = 1'b1; m[5][1] = 1'b1; end
            7'd43:  begin m[7][1] = 1'b1; m[7][3] = 1'b1; end
            7'd27:  begin m[7][1] = 1'b1; m[6][3] = 1'b1; end
            7'd24:  begin m[7][1] = 1'b1; m[6][2] = 1'b1; end
            7'd47:  begin m[7][1] = 1'b1; m[7][2] = 1'b1; end
            7'd48:  begin m[0][0] = 1'b1; m[3][0] = 1'b1; end
            7'd50:  begin m[0][0] = 1'b1; m[4][1] = 1'b1; end
            7'd53:  begin m[0][0] = 1'b1; m[7][0] = 1'b1; end
            7'd51:  begin m[0][0] = 1'b1; m[4][0] = 1'b1; end
            7'd126: begin m[0][0] = 1'b1; m[4][3] = 1'b1; end
            7'd125: begin m[0][0] = 1'b1; m[4][4] = 1'b1; end
            7'd123: begin m[0][0] = 1'b1; m[3][4] = 1'b1; end
            7'd124: begin m[0][0] = 1'b1; m[4][2] = 1'b1; end
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: src/kc2km_next.sv
// ----------------------------------------------------------------------------
// kc2km_next: next matrix state for one event word
// Applies key, modifier, frame tick and clear events to the current state.
// ----------------------------------------------------------------------------
module kc2km_next (
    input  kc2km_pkg::in_word_t word,
    input  kc2km_pkg::state_t   cur,
    input  logic [3:0]          hold,
    output kc2km_pkg::state_t   nxt
);
    import kc2km_pkg::*;

    matrix_t mask;

    assign mask = key_mask(word.key_code);

    always_comb
    begin
        nxt = cur;
        case (word.kind)
            KIND_DOWN:
            begin
                nxt.rows = cur.rows & ~mask;
            end
            KIND_UP:
            begin
                nxt.rows = cur.rows | mask;
            end
            KIND_MOD:
            begin
                case (word.key_code)
                    CODE_ALT_L, CODE_ALT_R:
                    begin
                        nxt.rows[0][0] = ~word.option_held;
                        nxt.rows[7][1] = ~word.option_held;
                    end
                    CODE_CAPS:
                    begin
                        nxt.rows[0][0]   = 1'b0;
                        nxt.rows[3][1]   = 1'b0;
                        nxt.caps_pending = 1'b1;
                    end
                    CODE_SHIFT_L, CODE_SHIFT_R:
                    begin
                        nxt.rows[0][0] = ~word.shift_held;
                    end
                    CODE_CTRL:
                    begin
                        nxt.rows[7][1] = ~word.control_held;
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
            KIND_FRAME:
            begin
                if (cur.caps_pending)
                begin
                    if (cur.caps_count > hold)
                    begin
                        nxt.rows[0][0]   = 1'b1;
                        nxt.rows[3][1]   = 1'b1;
                        nxt.caps_pending = 1'b0;
                        nxt.caps_count   = '0;
                    end
                    else if (cur.caps_count < CAPS_COUNT_MAX)
                    begin
                        nxt.caps_count = cur.caps_count + 4'd1;
                    end
                end
            end
            KIND_CLEAR:
            begin
                nxt.rows = {8{ROW_RESET}};
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: src/keycode_to_key_matrix_top.sv
// ----------------------------------------------------------------------------
// keycode_to_key_matrix_top: host key events to an 8-row keyboard matrix
//
// Event words enter on in_word with in_valid; the block raises in_stall to
// hold them off. Each accepted word updates the active-low matrix and yields
// one word on out_word with all eight rows after that event, qualified by
// out_valid and held off by out_stall.
// An accepted word is held in an input register; the matrix update lies
// between it and a result register, which drives out_valid and out_word.
// The word moves on once the result register is empty or its result is taken.
// One word is accepted every cycle while the receiver takes results; when
// out_stall is high the result holds, the input register keeps one more
// word, and then in_stall rises.
// The caps-lock hold count is written through cfg_valid/cfg_data, which is
// always ready; write it only while no word is in flight.
// Reset clears both stages, loads every row with 0xbf, clears the caps-lock
// chord state and sets the hold count to 2.
// ----------------------------------------------------------------------------
module keycode_to_key_matrix_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kc2km_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output kc2km_pkg::out_word_t out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);
    import kc2km_pkg::*;

    logic       s1_valid_reg;
    in_word_t   s1_word_reg;
    logic       out_valid_reg;
    out_word_t  out_word_reg;
    state_t     state_reg;
    state_t     state_next;
    logic [3:0] hold_reg;
    logic       advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    kc2km_next u_next (
        .word (s1_word_reg),
        .cur  (state_reg),
        .hold (hold_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{rows: {8{ROW_RESET}}, caps_pending: 1'b0, caps_count: 4'd0};
            hold_reg      <= HOLD_RESET;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                hold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg.row_0 <= state_next.rows[0];
            out_word_reg.row_1 <= state_next.rows[1];
            out_word_reg.row_2 <= state_next.rows[2];
            out_word_reg.row_3 <= state_next.rows[3];
            out_word_reg.row_4 <= state_next.rows[4];
            out_word_reg.row_5 <= state_next.rows[5];
            out_word_reg.row_6 <= state_next.rows[6];
            out_word_reg.row_7 <= state_next.rows[7];
        end
    end

endmodule

// File: src/kc2km_checker.sv
// ----------------------------------------------------------------------------
// kc2km_checker: port-level checks for the key matrix block
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module kc2km_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input kc2km_pkg::out_word_t out_word,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);
    import kc2km_pkg::*;

    // A result held by the receiver stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result word changed or dropped");

    // The input side is only held off while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while the output side was free");

    // A new result always traces back to an accepted input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word appeared without an accepted input word");

    // The hold register write port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write was refused");

endmodule

bind keycode_to_key_matrix_top kc2km_checker u_kc2km_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the host key to keyboard matrix block
// A driver feeds event words from a queue, a scoreboard model of the matrix
// predicts the eight rows after every word, and a monitor checks each result
// word row by row. The run walks through several caps-hold settings and
// several idle and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import kc2km_pkg::*;

    localparam int RUN_LIMIT      = 400000;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_LEN       = 300;
    localparam int RAND_PER_PHASE = 210;

    localparam int CAPS_ROW = 0;
    localparam int CAPS_COL = 0;
    localparam int SYM_ROW  = 7;
    localparam int SYM_COL  = 1;
    localparam int TWO_ROW  = 3;
    localparam int TWO_COL  = 1;

    typedef struct {
        logic [6:0] code;
        logic       chord;
        int         row_a;
        int         col_a;
        int         row_b;
        int         col_b;
    } key_entry_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = '0;

    key_entry_t key_map[$];
    in_word_t   pending_words[$];
    out_word_t  expected_rows_q[$];

    matrix_t    model_rows;
    logic       model_caps;
    logic [3:0] model_count;
    logic [3:0] model_hold;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken;
    int hold_left;

    int errors = 0;
    int items_queued = 0;
    int words_sent = 0;
    int words_checked = 0;
    int caps_releases = 0;
    int hold_writes = 0;
    int cycles = 0;
    int in_stall_cycles = 0;
    int stall_run = 0;
    int longest_stall = 0;

    keycode_to_key_matrix_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void set_key(input int row, input int col, input logic pressed);
        model_rows[row][col] = ~pressed;
    endfunction

    function automatic out_word_t step_matrix(input in_word_t w);
        logic pressed;
        pressed = (w.kind == KIND_DOWN);
        case (w.kind)
            KIND_DOWN, KIND_UP:
            begin
                foreach (key_map[i])
                begin
                    if (key_map[i].code == w.key_code)
                    begin
                        set_key(key_map[i].row_a, key_map[i].col_a, pressed);
                        if (key_map[i].chord)
                            set_key(key_map[i].row_b, key_map[i].col_b, pressed);
                    end
                end
            end
            KIND_MOD:
            begin
                case (w.key_code)
                    CODE_ALT_L, CODE_ALT_R:
                    begin
                        set_key(CAPS_ROW, CAPS_COL, w.option_held);
                        set_key(SYM_ROW, SYM_COL, w.option_held);
                    end
                    CODE_CAPS:
                    begin
                        set_key(CAPS_ROW, CAPS_COL, 1'b1);
                        set_key(TWO_ROW, TWO_COL, 1'b1);
                        model_caps = 1'b1;
                    end
                    CODE_SHIFT_L, CODE_SHIFT_R:
                        set_key(CAPS_ROW, CAPS_COL, w.shift_held);
                    CODE_CTRL:
                        set_key(SYM_ROW, SYM_COL, w.control_held);
                    default: ;
                endcase
            end
            KIND_FRAME:
            begin
                if (model_caps)
                begin
                    if (model_count > model_hold)
                    begin
                        set_key(CAPS_ROW, CAPS_COL, 1'b0);
                        set_key(TWO_ROW, TWO_COL, 1'b0);
                        model_caps = 1'b0;
                        model_count = '0;
                        caps_releases++;
                    end
                    else if (model_count < CAPS_COUNT_MAX)
                    begin
                        model_count++;
                    end
                end
            end
            KIND_CLEAR:
                model_rows = {8{ROW_RESET}};
            default: ;
        endcase
        return {model_rows[0], model_rows[1], model_rows[2], model_rows[3],
                model_rows[4], model_rows[5], model_rows[6], model_rows[7]};
    endfunction

    // Driver: when the current word is taken, offers the next pending word unless a random idle slot is drawn.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_rows_q.push_back(step_matrix(in_word));
                words_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_LEN;
            hold_taken <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: every result word is checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        out_word_t exp_word;
        matrix_t   exp_m;
        matrix_t   got_m;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rows_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, out_word);
            end
            else
            begin
                exp_word = expected_rows_q.pop_front();
                exp_m = exp_word;
                got_m = out_word;
                words_checked++;
                for (int i = 0; i < 8; i++)
                begin
                    if (got_m[7-i] !== exp_m[7-i])
                    begin
                        errors++;
                        $display("%0t: row_%0d mismatch, expected %h, actual %h",
                                 $time, i, exp_m[7-i], got_m[7-i]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (in_valid && in_stall)
            in_stall_cycles <= in_stall_cycles + 1;
        if (out_stall)
        begin
            stall_run <= stall_run + 1;
            if (stall_run + 1 > longest_stall)
                longest_stall <= stall_run + 1;
        end
        else
        begin
            stall_run <= 0;
        end
        if (cycles >= RUN_LIMIT)
        begin
            $display("%0t: run limit reached with %0d words still expected",
                     $time, expected_rows_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic add_key(input logic [6:0] code, input int row, input int col);
        key_entry_t e;
        e.code  = code;
        e.chord = 1'b0;
        e.row_a = row;
        e.col_a = col;
        e.row_b = 0;
        e.col_b = 0;
        key_map.push_back(e);
    endtask

    task automatic add_chord(input logic [6:0] code, input int r1, input int c1,
                             input int r2, input int c2);
        key_entry_t e;
        e.code  = code;
        e.chord = 1'b1;
        e.row_a = r1;
        e.col_a = c1;
        e.row_b = r2;
        e.col_b = c2;
        key_map.push_back(e);
    endtask

    task automatic queue_event(input logic [2:0] kind, input logic [6:0] code,
                               input logic [2:0] flags);
        in_word_t w;
        w.kind         = kind;
        w.key_code     = code;
        w.option_held  = flags[2];
        w.shift_held   = flags[1];
        w.control_held = flags[0];
        pending_words.push_back(w);
        items_queued++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_rows_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_hold(input logic [3:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_hold = value;
        hold_writes++;
    endtask

    task automatic queue_random_event();
        logic [12:0] bits;
        in_word_t    w;
        int          r;
        int          ticks;
        bits = 13'($urandom);
        w = bits;
        r = $urandom_range(99);
        if (r < 4)
        begin
            queue_event(KIND_MOD, CODE_CAPS, w[2:0]);
            ticks = $urandom_range(20);
            for (int i = 0; i < ticks; i++)
            begin
                bits = 13'($urandom);
                queue_event(KIND_FRAME, bits[9:3], bits[2:0]);
            end
            return;
        end
        else if (r < 40)
        begin
            w.kind = $urandom_range(1) ? KIND_UP : KIND_DOWN;
            w.key_code = key_map[$urandom_range(key_map.size() - 1)].code;
        end
        else if (r < 52)
        begin
            w.kind = KIND_MOD;
            w.key_code = 7'(CODE_SHIFT_L + $urandom_range(5));
        end
        else if (r < 78)
        begin
            w.kind = KIND_FRAME;
        end
        else if (r < 82)
        begin
            w.kind = KIND_CLEAR;
        end
        else if (r < 94)
        begin
            w.kind = 3'($urandom_range(KIND_CLEAR));
        end
        queue_event(w.kind, w.key_code, {w.option_held, w.shift_held, w.control_held});
    endtask

    initial
    begin : stimulus
        logic [3:0] hold_values [4];
        int         idle_send [4];
        int         idle_recv [4];
        int         start_count;

        add_key(6, 0, 1);   add_key(7, 0, 2);   add_key(8, 0, 3);   add_key(9, 0, 4);
        add_key(0, 1, 0);   add_key(1, 1, 1);   add_key(2, 1, 2);   add_key(3, 1, 3);
        add_key(5, 1, 4);   add_key(12, 2, 0);  add_key(13, 2, 1);  add_key(14, 2, 2);
        add_key(15, 2, 3);  add_key(17, 2, 4);  add_key(18, 3, 0);  add_key(19, 3, 1);
        add_key(20, 3, 2);  add_key(21, 3, 3);  add_key(23, 3, 4);  add_key(29, 4, 0);
        add_key(25, 4, 1);  add_key(28, 4, 2);  add_key(26, 4, 3);  add_key(22, 4, 4);
        add_key(35, 5, 0);  add_key(31, 5, 1);  add_key(34, 5, 2);  add_key(32, 5, 3);
        add_key(16, 5, 4);  add_key(36, 6, 0);  add_key(37, 6, 1);  add_key(40, 6, 2);
        add_key(38, 6, 3);  add_key(4, 6, 4);   add_key(49, 7, 0);  add_key(46, 7, 2);
        add_key(45, 7, 3);  add_key(11, 7, 4);
        add_chord(30, 0, 0, 3, 3);  add_chord(33, 0, 0, 3, 2);
        add_chord(39, 7, 1, 5, 0);  add_chord(41, 7, 1, 5, 1);
        add_chord(43, 7, 1, 7, 3);  add_chord(27, 7, 1, 6, 3);
        add_chord(24, 7, 1, 6, 2);  add_chord(47, 7, 1, 7, 2);
        add_chord(48, 0, 0, 3, 0);  add_chord(50, 0, 0, 4, 1);
        add_chord(53, 0, 0, 7, 0);  add_chord(51, 0, 0, 4, 0);
        add_chord(126, 0, 0, 4, 3); add_chord(125, 0, 0, 4, 4);
        add_chord(123, 0, 0, 3, 4); add_chord(124, 0, 0, 4, 2);

        model_rows  = {8{ROW_RESET}};
        model_caps  = 1'b0;
        model_count = '0;
        model_hold  = HOLD_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset hold count.
        queue_event(KIND_FRAME, 7'd0, 3'b000);
        queue_event(KIND_DOWN, 7'd0, 3'b000);
        queue_event(KIND_UP, 7'd0, 3'b111);
        queue_event(KIND_DOWN, 7'd127, 3'b111);
        queue_event(KIND_UP, 7'd127, 3'b000);
        queue_event(KIND_DOWN, 7'd30, 3'b000);
        queue_event(KIND_DOWN, 7'd6, 3'b000);
        queue_event(KIND_UP, 7'd30, 3'b000);
        queue_event(KIND_UP, 7'd6, 3'b000);
        queue_event(KIND_DOWN, 7'd39, 3'b000);
        queue_event(KIND_MOD, CODE_CAPS, 3'b000);
        queue_event(KIND_MOD, CODE_CAPS, 3'b111);
        repeat (4) queue_event(KIND_FRAME, 7'd127, 3'b111);
        queue_event(KIND_MOD, CODE_ALT_L, 3'b100);
        queue_event(KIND_MOD, CODE_ALT_R, 3'b011);
        queue_event(KIND_MOD, CODE_SHIFT_L, 3'b010);
        queue_event(KIND_MOD, CODE_SHIFT_R, 3'b101);
        queue_event(KIND_MOD, CODE_CTRL, 3'b001);
        queue_event(KIND_MOD, CODE_CTRL, 3'b110);
        queue_event(KIND_MOD, 7'd100, 3'b111);
        for (int k = KIND_CLEAR + 1; k < 8; k++)
            queue_event(3'(k), 7'd127, 3'b111);
        queue_event(KIND_DOWN, 7'd126, 3'b000);
        queue_event(KIND_CLEAR, 7'd0, 3'b000);
        wait_idle();

        hold_values[0] = 4'd0;
        hold_values[1] = CAPS_COUNT_MAX;
        hold_values[2] = 4'd14;
        hold_values[3] = 4'($urandom_range(15));
        idle_send[0] = 0;   idle_recv[0] = 0;
        idle_send[1] = 73;  idle_recv[1] = 0;
        idle_send[2] = 0;   idle_recv[2] = 73;
        idle_send[3] = 11;  idle_recv[3] = 11;

        for (int p = 0; p < 4; p++)
        begin
            write_hold(hold_values[p]);
            send_idle_pct  <= idle_send[p];
            recv_stall_pct <= idle_recv[p];
            if (p == 0)
                hold_req <= 1'b1;
            start_count = items_queued;
            while (items_queued - start_count < RAND_PER_PHASE)
                queue_random_event();
            wait_idle();
        end

        $display("Covered %0d event words, %0d result words, %0d caps-hold writes.",
                 words_sent, words_checked, hold_writes);
        $display("Caps chord released by frame tick %0d times; input held off %0d cycles.",
                 caps_releases, in_stall_cycles);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
